// ===== sv/pnea_pkg.sv =====
// Shared types, constants and arithmetic helpers for the normal-equation accumulator.
package pnea_pkg;

	localparam int MAX_COLS = 4096;
	localparam int MAX_ROWS = 4096;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int NSUMS = 44;
	localparam int NMAT = 36;
	localparam int SUM_AW = $clog2(NSUMS);

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_FOCAL_U  = 3'd0;
	localparam logic [2:0] REG_FOCAL_V  = 3'd1;
	localparam logic [2:0] REG_CENTER_U = 3'd2;
	localparam logic [2:0] REG_CENTER_V = 3'd3;
	localparam logic [2:0] REG_TAU_X    = 3'd4;
	localparam logic [2:0] REG_TAU_Y    = 3'd5;
	localparam logic [2:0] REG_TAU_Z    = 3'd6;

	typedef struct packed {
		logic        [23:0] focal_u;
		logic        [23:0] focal_v;
		logic        [23:0] center_u;
		logic        [23:0] center_v;
		logic signed [31:0] tau_x;
		logic signed [31:0] tau_y;
		logic signed [31:0] tau_z;
	} cfg_t;

	typedef struct packed {
		logic        [11:0] col;
		logic        [11:0] row;
		logic signed [15:0] grad_u;
		logic signed [15:0] grad_v;
		logic signed [15:0] residual;
		logic signed [15:0] light;
		logic               acc;
		logic               last;
	} item_t;

	typedef enum logic [4:0] {
		B_IDLE, B_XGO, B_XWT, B_YGO, B_YWT, B_MGU, B_MGV, B_MT1, B_MT2,
		B_WGO, B_WWT, B_ME3, B_ME4, B_ME5A, B_ME5B, B_ME5C, B_ACC, B_DRAIN,
		B_EMRD, B_EMWAIT, B_EMHOLD
	} bstate_t;

	function automatic logic signed [64:0] sx32(input logic signed [31:0] v);
		return {{33{v[31]}}, v};
	endfunction

	function automatic logic signed [64:0] sx64(input logic signed [63:0] v);
		return {v[63], v};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		if (v > 65'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -65'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = sx64(a) + sx64(b);
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		else
			return s[63:0];
	endfunction

	function automatic logic signed [63:0] asr16(input logic signed [63:0] v);
		return v >>> 16;
	endfunction

	// start of row k in the packed lower triangle
	function automatic logic [SUM_AW-1:0] tri_base(input logic [2:0] k);
		logic [SUM_AW-1:0] b;
		case (k)
			3'd0: b = SUM_AW'(0);
			3'd1: b = SUM_AW'(1);
			3'd2: b = SUM_AW'(3);
			3'd3: b = SUM_AW'(6);
			3'd4: b = SUM_AW'(10);
			3'd5: b = SUM_AW'(15);
			3'd6: b = SUM_AW'(21);
			3'd7: b = SUM_AW'(28);
			default: b = '0;
		endcase
		return b;
	endfunction

	function automatic logic [2:0] tri_k(input logic [SUM_AW-1:0] j);
		logic [2:0] k;
		k = '0;
		for (int i = 1; i < 8; i++) begin
			if (j >= tri_base(3'(i)))
				k = 3'(i);
		end
		return k;
	endfunction

endpackage

// ===== sv/pnea_div.sv =====
// Radix-2 restoring divider: 64-bit unsigned dividend by 32-bit divisor, one bit a cycle.
module pnea_div import pnea_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [63:0] quo_q;
	logic [32:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[63]};
	assign fits = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/pnea_front.sv =====
// Input side: takes pixel requests, drops those that add nothing, queues the rest.
module pnea_front import pnea_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic        [11:0] pixel_col,
	input  logic        [11:0] pixel_row,
	input  logic signed [15:0] grad_u,
	input  logic signed [15:0] grad_v,
	input  logic signed [15:0] residual,
	input  logic signed [15:0] light_term,
	input  logic               pixel_valid,
	input  logic               last_pixel,
	output item_t              head,
	output logic               head_valid,
	input  logic               pop
);

	item_t              queue_mem [QDEPTH];
	logic [QPTR_W-1:0]  wp_q;
	logic [QPTR_W-1:0]  rp_q;
	logic [QPTR_W:0]    cnt_q;
	logic               take;
	logic               push;
	logic               in_range;
	item_t              item;

	assign in_ready = cnt_q < (QPTR_W+1)'(QDEPTH);
	assign take = in_valid && in_ready;
	assign in_range = (32'(pixel_col) < MAX_COLS) && (32'(pixel_row) < MAX_ROWS);

	always_comb begin
		item.col = pixel_col;
		item.row = pixel_row;
		item.grad_u = grad_u;
		item.grad_v = grad_v;
		item.residual = residual;
		item.light = light_term;
		item.acc = pixel_valid && in_range;
		item.last = last_pixel;
	end

	// a masked pixel that does not close the frame needs no back-end work
	assign push = take && (item.acc || item.last);

	always_ff @(posedge clk) begin
		if (push)
			queue_mem[wp_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign head = queue_mem[rp_q];
	assign head_valid = cnt_q != '0;

endmodule

// ===== sv/pnea_back.sv =====
// Back end: Jacobian row sequencer, shared multiplier, sum memory and row readout.
module pnea_back import pnea_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  item_t              head,
	input  logic               head_valid,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [2:0]  row_index,
	output logic signed [63:0] entry_0,
	output logic signed [63:0] entry_1,
	output logic signed [63:0] entry_2,
	output logic signed [63:0] entry_3,
	output logic signed [63:0] entry_4,
	output logic signed [63:0] entry_5,
	output logic signed [63:0] entry_6,
	output logic signed [63:0] entry_7,
	output logic signed [63:0] rhs_value,
	output logic               last_row
);

	bstate_t st_q, st_d;

	logic signed [31:0] x_q, y_q, dx_q, dy_q, gu_q, gv_q, gw_q, e3_q, e4_q, e5_q;
	logic signed [63:0] t1_q;
	logic               sgn_q;
	logic [SUM_AW-1:0]  j_q;
	logic [3:0]         c_q;
	logic [2:0]         r_q;
	logic               ov_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_q;

	logic        div_start, div_done;
	logic [63:0] dividend, quotient;
	logic [31:0] divisor;

	logic signed [63:0] sums_mem [NSUMS];
	logic [NSUMS-1:0]   vld_q;
	logic [SUM_AW-1:0]  rd_addr;
	logic signed [63:0] rd_s1;
	logic               rdv_s1;
	logic               act_s1, em_s1;
	logic [SUM_AW-1:0]  wa_s1;
	logic [3:0]         ec_s1;
	logic               acc_issue, em_issue;
	logic signed [63:0] ent_q [9];
	logic signed [63:0] old_sum, wdata;

	logic signed [25:0] numx, numy;
	logic [24:0]        absx, absy;
	logic signed [63:0] numw;
	logic [63:0]        absw;
	logic [31:0]        abstz;
	logic signed [64:0] qs;
	logic signed [31:0] e_w [8];
	logic signed [31:0] d16;
	logic [2:0]         jk, jl, hi, lo;
	logic signed [63:0] negp;

	assign numx = $signed({6'b0, head.col, 8'b0}) - $signed({2'b0, cfg.center_u});
	assign numy = $signed({6'b0, head.row, 8'b0}) - $signed({2'b0, cfg.center_v});
	assign absx = numx[25] ? 25'(-numx) : numx[24:0];
	assign absy = numy[25] ? 25'(-numy) : numy[24:0];
	assign numw = sat_add64(t1_q, prod_q);
	assign absw = numw[63] ? 64'(-numw) : 64'(numw);
	assign abstz = cfg.tau_z[31] ? 32'(-cfg.tau_z) : 32'(cfg.tau_z);
	assign qs = sgn_q ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
	assign d16 = {{8{head.residual[15]}}, head.residual, 8'b0};
	assign negp = -prod_q;

	always_comb begin
		e_w[0] = gu_q;
		e_w[1] = gv_q;
		e_w[2] = gw_q;
		e_w[3] = e3_q;
		e_w[4] = e4_q;
		e_w[5] = e5_q;
		e_w[6] = {{8{head.light[15]}}, head.light, 8'b0};
		e_w[7] = 32'sd65536;
	end

	assign jk = (j_q < SUM_AW'(NMAT)) ? tri_k(j_q) : 3'(j_q - SUM_AW'(NMAT));
	assign jl = 3'(j_q - tri_base(jk));
	assign hi = (c_q[2:0] > r_q) ? c_q[2:0] : r_q;
	assign lo = (c_q[2:0] > r_q) ? r_q : c_q[2:0];

	pnea_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: begin
				if (head_valid)
					st_d = head.acc ? B_XGO : B_EMRD;
			end
			B_XGO: st_d = (cfg.focal_u == '0) ? B_YGO : B_XWT;
			B_XWT: if (div_done) st_d = B_YGO;
			B_YGO: st_d = (cfg.focal_v == '0) ? B_MGU : B_YWT;
			B_YWT: if (div_done) st_d = B_MGU;
			B_MGU: st_d = B_MGV;
			B_MGV: st_d = B_MT1;
			B_MT1: st_d = B_MT2;
			B_MT2: st_d = B_WGO;
			B_WGO: st_d = (cfg.tau_z == '0) ? B_ME3 : B_WWT;
			B_WWT: if (div_done) st_d = B_ME3;
			B_ME3: st_d = B_ME4;
			B_ME4: st_d = B_ME5A;
			B_ME5A: st_d = B_ME5B;
			B_ME5B: st_d = B_ME5C;
			B_ME5C: st_d = B_ACC;
			B_ACC: if (j_q == SUM_AW'(NSUMS - 1)) st_d = B_DRAIN;
			B_DRAIN: st_d = head.last ? B_EMRD : B_IDLE;
			B_EMRD: if (c_q == 4'd8) st_d = B_EMWAIT;
			B_EMWAIT: st_d = B_EMHOLD;
			B_EMHOLD: begin
				if (out_ready)
					st_d = (r_q == 3'd7) ? B_IDLE : B_EMRD;
			end
			default: st_d = B_IDLE;
		endcase
	end

	// control outputs and operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		dividend = '0;
		divisor = '0;
		pop = 1'b0;
		acc_issue = 1'b0;
		em_issue = 1'b0;
		rd_addr = j_q;
		case (st_q)
			B_XGO: begin
				div_start = cfg.focal_u != '0;
				dividend = 64'({absx, 16'b0});
				divisor = 32'(cfg.focal_u);
			end
			B_YGO: begin
				div_start = cfg.focal_v != '0;
				dividend = 64'({absy, 16'b0});
				divisor = 32'(cfg.focal_v);
			end
			B_MGU: begin
				mul_a = {{16{head.grad_u[15]}}, head.grad_u};
				mul_b = {8'b0, cfg.focal_u};
			end
			B_MGV: begin
				mul_a = {{16{head.grad_v[15]}}, head.grad_v};
				mul_b = {8'b0, cfg.focal_v};
			end
			B_MT1: begin
				mul_a = gu_q;
				mul_b = dx_q;
			end
			B_MT2: begin
				mul_a = gv_q;
				mul_b = dy_q;
			end
			B_WGO: begin
				div_start = cfg.tau_z != '0;
				dividend = absw;
				divisor = abstz;
			end
			B_ME3: begin
				mul_a = gw_q;
				mul_b = y_q;
			end
			B_ME4: begin
				mul_a = gw_q;
				mul_b = x_q;
			end
			B_ME5A: begin
				mul_a = x_q;
				mul_b = gv_q;
			end
			B_ME5B: begin
				mul_a = y_q;
				mul_b = gu_q;
			end
			B_ACC: begin
				acc_issue = 1'b1;
				mul_a = e_w[jk];
				mul_b = (j_q < SUM_AW'(NMAT)) ? e_w[jl] : d16;
			end
			B_DRAIN: pop = !head.last;
			B_EMRD: begin
				em_issue = 1'b1;
				rd_addr = (c_q == 4'd8) ? SUM_AW'(NMAT) + SUM_AW'(r_q)
					: tri_base(hi) + SUM_AW'(lo);
			end
			B_EMHOLD: pop = out_ready && (r_q == 3'd7);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// sum memory, registered read
	assign old_sum = rdv_s1 ? rd_s1 : 64'sd0;
	assign wdata = sat_add64(old_sum, asr16(prod_q));

	always_ff @(posedge clk) begin
		rd_s1 <= sums_mem[rd_addr];
		if (act_s1)
			sums_mem[wa_s1] <= wdata;
		if (em_s1)
			ent_q[ec_s1] <= old_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			vld_q <= '0;
			rdv_s1 <= 1'b0;
			act_s1 <= 1'b0;
			em_s1 <= 1'b0;
			wa_s1 <= '0;
			ec_s1 <= '0;
			j_q <= '0;
			c_q <= '0;
			r_q <= '0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			rdv_s1 <= vld_q[rd_addr];
			act_s1 <= acc_issue;
			em_s1 <= em_issue;
			wa_s1 <= j_q;
			ec_s1 <= c_q;
			if (act_s1)
				vld_q[wa_s1] <= 1'b1;
			if (st_q == B_ME5C)
				j_q <= '0;
			else if (acc_issue)
				j_q <= j_q + 1'b1;
			if (em_issue)
				c_q <= c_q + 4'd1;
			if (st_q == B_EMWAIT)
				ov_q <= 1'b1;
			if (st_q == B_EMHOLD && out_ready) begin
				ov_q <= 1'b0;
				c_q <= '0;
				r_q <= r_q + 3'd1;
				// frame done: every sum reads as zero again
				if (r_q == 3'd7)
					vld_q <= '0;
			end
		end
	end

	// Jacobian datapath
	always_ff @(posedge clk) begin
		case (st_q)
			B_XGO: begin
				sgn_q <= numx[25];
				x_q <= '0;
			end
			B_XWT: if (div_done) x_q <= sat32(qs);
			B_YGO: begin
				sgn_q <= numy[25];
				y_q <= '0;
			end
			B_YWT: if (div_done) y_q <= sat32(qs);
			B_MGU: begin
				dx_q <= sat32(sx32(x_q) - sx32(cfg.tau_x));
				dy_q <= sat32(sx32(y_q) - sx32(cfg.tau_y));
			end
			B_MGV: gu_q <= sat32(sx64(prod_q));
			B_MT1: gv_q <= sat32(sx64(prod_q));
			B_MT2: t1_q <= prod_q;
			B_WGO: begin
				sgn_q <= numw[63] ^ cfg.tau_z[31];
				gw_q <= '0;
			end
			B_WWT: if (div_done) gw_q <= sat32(qs);
			B_ME4: e3_q <= sat32(sx64(asr16(prod_q)));
			B_ME5A: e4_q <= sat32(sx64(asr16(negp)));
			B_ME5B: t1_q <= prod_q;
			B_ME5C: e5_q <= sat32(sx64(asr16(sat_add64(t1_q, negp))));
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign row_index = r_q;
	assign entry_0 = ent_q[0];
	assign entry_1 = ent_q[1];
	assign entry_2 = ent_q[2];
	assign entry_3 = ent_q[3];
	assign entry_4 = ent_q[4];
	assign entry_5 = ent_q[5];
	assign entry_6 = ent_q[6];
	assign entry_7 = ent_q[7];
	assign rhs_value = ent_q[8];
	assign last_row = r_q == 3'd7;

endmodule

// ===== sv/photometric_normal_equation_accumulator.sv =====
// Top level: register file, input queue front end and accumulation back end.
//
//   channel  direction  handshake            payload
//   in       request    in_valid/in_ready    pixel_col .. last_pixel
//   out      result     out_valid/out_ready  row_index, entry_0..7, rhs_value, last_row
//   cfg      write/read psel/penable/pready  paddr, pwdata, prdata
//
// A kept pixel runs in the back end through up to three 64-step divisions (x, y, gw) on the serial
// divider, each skipped when its divisor is zero, and then through the 44 sum updates.
// A masked pixel that does not end the frame is dropped by the front end and never reaches the back end.
// A frame end sends 8 rows, each held until out_ready takes it.
// A four-entry queue lets requests arrive while the back end works or the output stalls.
// Reset clears all sums through per-entry valid bits.
module photometric_normal_equation_accumulator import pnea_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic        [11:0] pixel_col,
	input  logic        [11:0] pixel_row,
	input  logic signed [15:0] grad_u,
	input  logic signed [15:0] grad_v,
	input  logic signed [15:0] residual,
	input  logic signed [15:0] light_term,
	input  logic               pixel_valid,
	input  logic               last_pixel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [2:0]  row_index,
	output logic signed [63:0] entry_0,
	output logic signed [63:0] entry_1,
	output logic signed [63:0] entry_2,
	output logic signed [63:0] entry_3,
	output logic signed [63:0] entry_4,
	output logic signed [63:0] entry_5,
	output logic signed [63:0] entry_6,
	output logic signed [63:0] entry_7,
	output logic signed [63:0] rhs_value,
	output logic               last_row
);

	cfg_t       cfg_q;
	item_t      head;
	logic       head_valid;
	logic       pop;
	logic       wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_u <= 24'd256;
			cfg_q.focal_v <= 24'd256;
			cfg_q.center_u <= '0;
			cfg_q.center_v <= '0;
			cfg_q.tau_x <= '0;
			cfg_q.tau_y <= '0;
			cfg_q.tau_z <= 32'sd65536;
		end else if (wr) begin
			case (idx)
				REG_FOCAL_U: cfg_q.focal_u <= pwdata[23:0];
				REG_FOCAL_V: cfg_q.focal_v <= pwdata[23:0];
				REG_CENTER_U: cfg_q.center_u <= pwdata[23:0];
				REG_CENTER_V: cfg_q.center_v <= pwdata[23:0];
				REG_TAU_X: cfg_q.tau_x <= pwdata;
				REG_TAU_Y: cfg_q.tau_y <= pwdata;
				REG_TAU_Z: cfg_q.tau_z <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FOCAL_U: prdata = {8'b0, cfg_q.focal_u};
			REG_FOCAL_V: prdata = {8'b0, cfg_q.focal_v};
			REG_CENTER_U: prdata = {8'b0, cfg_q.center_u};
			REG_CENTER_V: prdata = {8'b0, cfg_q.center_v};
			REG_TAU_X: prdata = cfg_q.tau_x;
			REG_TAU_Y: prdata = cfg_q.tau_y;
			REG_TAU_Z: prdata = cfg_q.tau_z;
			default: prdata = '0;
		endcase
	end

	pnea_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.grad_u      (grad_u),
		.grad_v      (grad_v),
		.residual    (residual),
		.light_term  (light_term),
		.pixel_valid (pixel_valid),
		.last_pixel  (last_pixel),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop)
	);

	pnea_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.row_index  (row_index),
		.entry_0    (entry_0),
		.entry_1    (entry_1),
		.entry_2    (entry_2),
		.entry_3    (entry_3),
		.entry_4    (entry_4),
		.entry_5    (entry_5),
		.entry_6    (entry_6),
		.entry_7    (entry_7),
		.rhs_value  (rhs_value),
		.last_row   (last_row)
	);

endmodule
